@@ hw/rtl/hdds_pkg.sv @@
`timescale 1ns / 1ps

package hdds_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF     = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int GUARD_BITS   = 16;
  localparam int ACC_W        = 32;

  localparam int MAX_SPEED_W = 16;
  localparam int THR_W       = 15;
  localparam int SPEED_W     = 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_TURN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_TURN = 2'd2;

  localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST = 16'd2560;
  localparam logic [THR_W-1:0]       NO_TURN_RST   = 15'd1820;
  localparam logic [THR_W-1:0]       SOFT_TURN_RST = 15'd12743;

  // pi in the angle accumulator
  localparam logic [ACC_W-1:0] ACC_PI = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_SOFT     = 2'd1,
    MODE_HARD     = 2'd2
  } turn_mode_e;

  // atan(2^-i), 2^31 standing for pi
  localparam logic [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

endpackage

@@ hw/rtl/hdds_cordic_cell.sv @@
`timescale 1ns / 1ps

module hdds_cordic_cell
  import hdds_pkg::*;
#(
  parameter int IDX  = 0,
  parameter int XY_W = 34,
  parameter int PW   = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic [ACC_W-1:0]       acc_i,
  input  logic [PW-1:0]          pass_i,
  output logic                   valid_o,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o,
  output logic [ACC_W-1:0]       acc_o,
  output logic [PW-1:0]          pass_o
);

  logic                   valid_q;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [XY_W-1:0] x_d, y_d, x_q, y_q;
  logic [ACC_W-1:0]       acc_d, acc_q;
  logic [PW-1:0]          pass_q;

  // rotate toward the x axis; floor shifts
  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (!y_i[XY_W-1]) begin
      x_d   = x_i + ys;
      y_d   = y_i - xs;
      acc_d = acc_i + ATAN_TAB[IDX];
    end else begin
      x_d   = x_i - ys;
      y_d   = y_i + xs;
      acc_d = acc_i - ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign acc_o   = acc_q;
  assign pass_o  = pass_q;

endmodule

@@ hw/rtl/hdds_sqrt_cell.sv @@
`timescale 1ns / 1ps

module hdds_sqrt_cell #(
  parameter int CW = 16,
  parameter int PW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*CW-1:0] n_i,
  input  logic [CW+1:0]   rem_i,
  input  logic [CW-1:0]   root_i,
  input  logic [PW-1:0]   pass_i,
  output logic            valid_o,
  output logic [2*CW-1:0] n_o,
  output logic [CW+1:0]   rem_o,
  output logic [CW-1:0]   root_o,
  output logic [PW-1:0]   pass_o
);

  logic            valid_q;
  logic [CW+3:0]   rem2, trial, diff;
  logic            ge;
  logic [2*CW-1:0] n_d, n_q;
  logic [CW+1:0]   rem_d, rem_q;
  logic [CW-1:0]   root_d, root_q;
  logic [PW-1:0]   pass_q;

  // one root bit: bring down two radicand bits, try 4*root + 1
  always_comb begin
    rem2   = {rem_i, n_i[2*CW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    diff   = rem2 - trial;
    ge     = (rem2 >= trial);
    rem_d  = ge ? diff[CW+1:0] : rem2[CW+1:0];
    root_d = {root_i[CW-2:0], ge};
    n_d    = {n_i[2*CW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pass_o  = pass_q;

endmodule

@@ hw/rtl/hdds_div_cell.sv @@
`timescale 1ns / 1ps

module hdds_div_cell
  import hdds_pkg::*;
#(
  parameter int PW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [THR_W-1:0]       div_i,
  input  logic [THR_W-1:0]       rem_i,
  input  logic [MAX_SPEED_W-1:0] num_i,
  input  logic [MAX_SPEED_W-1:0] quo_i,
  input  logic [PW-1:0]          pass_i,
  output logic                   valid_o,
  output logic [THR_W-1:0]       rem_o,
  output logic [MAX_SPEED_W-1:0] num_o,
  output logic [MAX_SPEED_W-1:0] quo_o,
  output logic [PW-1:0]          pass_o
);

  logic                   valid_q;
  logic [THR_W:0]         rem2, dvs, diff;
  logic                   ge;
  logic [THR_W-1:0]       rem_d, rem_q;
  logic [MAX_SPEED_W-1:0] num_d, num_q, quo_d, quo_q;
  logic [PW-1:0]          pass_q;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem2  = {rem_i, num_i[MAX_SPEED_W-1]};
    dvs   = {1'b0, div_i};
    diff  = rem2 - dvs;
    ge    = (rem2 >= dvs);
    rem_d = ge ? diff[THR_W-1:0] : rem2[THR_W-1:0];
    num_d = {num_i[MAX_SPEED_W-2:0], 1'b0};
    quo_d = {quo_i[MAX_SPEED_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      num_q  <= num_d;
      quo_q  <= quo_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;
  assign pass_o  = pass_q;

endmodule

@@ hw/rtl/heading_to_diff_drive_speeds_core.sv @@
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless the last stage is full and the output is
//   stalled; every CORDIC iteration, square root bit and quotient bit is a cell of
//   its own, and the output register lets the pipeline fill.
// Reset: clears all valid flags and loads the register defaults; no clearing pass.
module heading_to_diff_drive_speeds_core
  import hdds_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]            cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COMPONENT_BITS-1:0] heading_x_i,
  input  logic signed [COMPONENT_BITS-1:0] heading_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SPEED_W-1:0]        left_speed_o,
  output logic signed [SPEED_W-1:0]        right_speed_o,
  output logic [1:0]                       turn_mode_o
);

  localparam int C      = COMPONENT_BITS;
  localparam int A      = ANGLE_BITS;
  localparam int XY_W   = C + GUARD_BITS + 2;
  localparam int N_W    = 2 * C;
  localparam int SH     = ACC_W - A;
  localparam int TW     = (A > THR_W) ? A : THR_W;
  localparam int RW     = (C > MAX_SPEED_W) ? C : MAX_SPEED_W;
  localparam int NUM_W  = THR_W + MAX_SPEED_W;
  localparam int SUM_W  = MAX_SPEED_W + 2;
  localparam int DIV_STEPS = MAX_SPEED_W;

  localparam logic [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (SH - 1);
  localparam logic [A-1:0] ANG_NEG_PI   = {1'b1, {(A-1){1'b0}}};
  localparam logic [A-1:0] ANG_HALF_PI  = {2'b01, {(A-2){1'b0}}};
  localparam logic [A-1:0] ANG_NEG_HALF = {2'b11, {(A-2){1'b0}}};

  typedef struct packed {
    logic [N_W-1:0] n;
    logic           spec;
    logic [A-1:0]   spec_ang;
  } cord_pass_t;

  typedef struct packed {
    logic [THR_W-1:0] abs_ang;
    turn_mode_e       mode;
    logic             pos;
  } sq_pass_t;

  typedef struct packed {
    logic [MAX_SPEED_W-1:0] base;
    turn_mode_e             mode;
    logic                   pos;
  } div_pass_t;

  localparam int CP_W = $bits(cord_pass_t);
  localparam int SP_W = $bits(sq_pass_t);
  localparam int DP_W = $bits(div_pass_t);

  // ---------------------------------------------------------------- config
  logic [MAX_SPEED_W-1:0] max_speed_q;
  logic [THR_W-1:0]       no_turn_q, soft_turn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MAX_SPEED_RST;
      no_turn_q   <= NO_TURN_RST;
      soft_turn_q <= SOFT_TURN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_SPEED: max_speed_q <= cfg_wdata_i[MAX_SPEED_W-1:0];
        REG_NO_TURN:   no_turn_q   <= cfg_wdata_i[THR_W-1:0];
        REG_SOFT_TURN: soft_turn_q <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic adv, last_v, out_valid_q;

  // advance the whole line unless its last stage is full and the output cannot take it
  assign adv        = !last_v || !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------- front
  logic                  v0_q, v1_q, v2_q;
  logic signed [C-1:0]   x0_q, y0_q, x1_q, y1_q;
  logic signed [N_W-1:0] xx_d, yy_d, xx1_q, yy1_q;

  assign xx_d = x0_q * x0_q;
  assign yy_d = y0_q * y0_q;

  logic signed [XY_W-1:0] x_ext, y_ext, cx_d, cy_d, cx2_q, cy2_q;
  logic [ACC_W-1:0]       acc_d, acc2_q;
  logic                   x_neg, x_zero, y_zero;
  cord_pass_t             cp_d, cp2_q;

  always_comb begin
    x_ext  = XY_W'(x1_q);
    y_ext  = XY_W'(y1_q);
    x_neg  = x1_q[C-1];
    x_zero = (x1_q == '0);
    y_zero = (y1_q == '0);
    // left half plane: negate the vector and start the angle at pi
    cx_d  = (x_neg ? -x_ext : x_ext) <<< GUARD_BITS;
    cy_d  = (x_neg ? -y_ext : y_ext) <<< GUARD_BITS;
    acc_d = x_neg ? ACC_PI : '0;
    cp_d.n    = $unsigned(xx1_q + yy1_q);
    cp_d.spec = x_zero || y_zero;
    if (y_zero) begin
      cp_d.spec_ang = x_neg ? ANG_NEG_PI : '0;
    end else if (x_zero) begin
      cp_d.spec_ang = y1_q[C-1] ? ANG_NEG_HALF : ANG_HALF_PI;
    end else begin
      cp_d.spec_ang = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q   <= heading_x_i;
      y0_q   <= heading_y_i;
      x1_q   <= x0_q;
      y1_q   <= y0_q;
      xx1_q  <= xx_d;
      yy1_q  <= yy_d;
      cx2_q  <= cx_d;
      cy2_q  <= cy_d;
      acc2_q <= acc_d;
      cp2_q  <= cp_d;
    end
  end

  // ---------------------------------------------------------------- CORDIC
  logic                   c_v   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_x   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_y   [CORDIC_STEPS+1];
  logic [ACC_W-1:0]       c_acc [CORDIC_STEPS+1];
  cord_pass_t             c_pass[CORDIC_STEPS+1];

  assign c_v[0]    = v2_q;
  assign c_x[0]    = cx2_q;
  assign c_y[0]    = cy2_q;
  assign c_acc[0]  = acc2_q;
  assign c_pass[0] = cp2_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    hdds_cordic_cell #(
      .IDX (i),
      .XY_W(XY_W),
      .PW  (CP_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(c_v[i]),
      .x_i    (c_x[i]),
      .y_i    (c_y[i]),
      .acc_i  (c_acc[i]),
      .pass_i (c_pass[i]),
      .valid_o(c_v[i+1]),
      .x_o    (c_x[i+1]),
      .y_o    (c_y[i+1]),
      .acc_o  (c_acc[i+1]),
      .pass_o (c_pass[i+1])
    );
  end

  // ---------------------------------------------------------------- angle
  logic             v3_q, v4_q;
  logic [ACC_W-1:0] acc_rnd;
  logic [A-1:0]     ang_d, ang3_q, abs_ang;
  logic [N_W-1:0]   n3_q, n4_q;
  logic [TW-1:0]    abs_ext;
  sq_pass_t         sp_d, sp4_q;

  // round half up, then keep the top ANGLE_BITS bits: that is the wrap into [-pi, pi)
  assign acc_rnd = c_acc[CORDIC_STEPS] + ACC_ROUND;
  assign ang_d   = c_pass[CORDIC_STEPS].spec ? c_pass[CORDIC_STEPS].spec_ang
                                             : acc_rnd[ACC_W-1:SH];

  always_comb begin
    abs_ang = ang3_q[A-1] ? -ang3_q : ang3_q;
    abs_ext = TW'(abs_ang);
    sp_d.abs_ang = abs_ext[THR_W-1:0];
    sp_d.pos     = !ang3_q[A-1] && (ang3_q != '0);
    priority if (abs_ext <= TW'(no_turn_q)) begin
      sp_d.mode = MODE_STRAIGHT;
    end else if (abs_ext <= TW'(soft_turn_q)) begin
      sp_d.mode = MODE_SOFT;
    end else begin
      sp_d.mode = MODE_HARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v3_q <= c_v[CORDIC_STEPS];
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang3_q <= ang_d;
      n3_q   <= c_pass[CORDIC_STEPS].n;
      n4_q   <= n3_q;
      sp4_q  <= sp_d;
    end
  end

  // ---------------------------------------------------------------- length
  logic           s_v   [C+1];
  logic [N_W-1:0] s_n   [C+1];
  logic [C+1:0]   s_rem [C+1];
  logic [C-1:0]   s_root[C+1];
  sq_pass_t       s_pass[C+1];

  assign s_v[0]    = v4_q;
  assign s_n[0]    = n4_q;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_pass[0] = sp4_q;

  for (genvar i = 0; i < C; i++) begin : g_sqrt
    hdds_sqrt_cell #(
      .CW(C),
      .PW(SP_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(s_v[i]),
      .n_i    (s_n[i]),
      .rem_i  (s_rem[i]),
      .root_i (s_root[i]),
      .pass_i (s_pass[i]),
      .valid_o(s_v[i+1]),
      .n_o    (s_n[i+1]),
      .rem_o  (s_rem[i+1]),
      .root_o (s_root[i+1]),
      .pass_o (s_pass[i+1])
    );
  end

  // ---------------------------------------------------------------- turn offset
  logic                   v5_q, v6_q, v7_q;
  logic                   root_lt;
  div_pass_t              dp_d, dp5_q, dp6_q, dp7_q;
  logic [THR_W-1:0]       abs5_q;
  logic [NUM_W-1:0]       prod_d, prod6_q, num7_q;

  always_comb begin
    root_lt   = (RW'(s_root[C]) < RW'(max_speed_q));
    dp_d.base = root_lt ? MAX_SPEED_W'(s_root[C]) : max_speed_q;
    dp_d.mode = s_pass[C].mode;
    dp_d.pos  = s_pass[C].pos;
  end

  assign prod_d = dp5_q.base * abs5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v5_q <= s_v[C];
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp5_q   <= dp_d;
      abs5_q  <= s_pass[C].abs_ang;
      dp6_q   <= dp5_q;
      prod6_q <= prod_d;
      dp7_q   <= dp6_q;
      num7_q  <= prod6_q + NUM_W'(soft_turn_q >> 1);
    end
  end

  // quotient fits MAX_SPEED_W bits whenever the soft mode applies
  logic                   d_v   [DIV_STEPS+1];
  logic [THR_W-1:0]       d_rem [DIV_STEPS+1];
  logic [MAX_SPEED_W-1:0] d_num [DIV_STEPS+1];
  logic [MAX_SPEED_W-1:0] d_quo [DIV_STEPS+1];
  div_pass_t              d_pass[DIV_STEPS+1];

  assign d_v[0]    = v7_q;
  assign d_rem[0]  = num7_q[NUM_W-1:MAX_SPEED_W];
  assign d_num[0]  = num7_q[MAX_SPEED_W-1:0];
  assign d_quo[0]  = '0;
  assign d_pass[0] = dp7_q;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    hdds_div_cell #(
      .PW(DP_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(d_v[i]),
      .div_i  (soft_turn_q),
      .rem_i  (d_rem[i]),
      .num_i  (d_num[i]),
      .quo_i  (d_quo[i]),
      .pass_i (d_pass[i]),
      .valid_o(d_v[i+1]),
      .rem_o  (d_rem[i+1]),
      .num_o  (d_num[i+1]),
      .quo_o  (d_quo[i+1]),
      .pass_o (d_pass[i+1])
    );
  end

  assign last_v = d_v[DIV_STEPS];

  // ---------------------------------------------------------------- wheels
  logic signed [SUM_W-1:0] base_s, t_s, mx_s, slow, fast, left_d, right_d;
  logic signed [SPEED_W-1:0] left_q, right_q;
  turn_mode_e                mode_q;
  div_pass_t                 fin;

  always_comb begin
    fin    = d_pass[DIV_STEPS];
    base_s = $signed({2'b00, fin.base});
    t_s    = $signed({2'b00, d_quo[DIV_STEPS]});
    mx_s   = $signed({2'b00, max_speed_q});
    unique case (fin.mode)
      MODE_STRAIGHT: begin
        slow = base_s;
        fast = base_s;
      end
      MODE_SOFT: begin
        slow = base_s - t_s;
        fast = base_s + t_s;
        if (slow > mx_s) slow = mx_s;
        if (fast > mx_s) fast = mx_s;
        if (slow < -mx_s) slow = -mx_s;
        if (fast < -mx_s) fast = -mx_s;
      end
      default: begin
        slow = -mx_s;
        fast = mx_s;
      end
    endcase
    // slow wheel on the left for a positive angle
    left_d  = fin.pos ? slow : fast;
    right_d = fin.pos ? fast : slow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_v) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_v) begin
      left_q  <= left_d[SPEED_W-1:0];
      right_q <= right_d[SPEED_W-1:0];
      mode_q  <= fin.mode;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign turn_mode_o   = 2'(mode_q);

endmodule

@@ tb/heading_to_diff_drive_speeds_core_tb.sv @@
`timescale 1ns / 1ps

module heading_to_diff_drive_speeds_core_tb;
  import hdds_pkg::*;

  localparam int CW          = COMPONENT_BITS_DEF;
  localparam int DUT_LATENCY = 54 + COMPONENT_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 30;
  localparam longint HALF_TURN = 64'sd1 <<< (ANGLE_BITS_DEF - 1);
  localparam int ACC_SHIFT = ACC_W - ANGLE_BITS_DEF;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    turn_mode_e                mode;
  } wheel_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] heading_x = '0;
  logic signed [CW-1:0] heading_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic [1:0] turn_mode;

  wheel_cmd_t pending_speeds[$];
  longint cfg_max_speed = MAX_SPEED_RST;
  longint cfg_no_turn   = NO_TURN_RST;
  longint cfg_soft_turn = SOFT_TURN_RST;

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic stall_hold = 1'b0;

  heading_to_diff_drive_speeds_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .heading_x_i  (heading_x),
    .heading_y_i  (heading_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .left_speed_o (left_speed),
    .right_speed_o(right_speed),
    .turn_mode_o  (turn_mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_speeds.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= stall_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // binary angle of (x, y), wrapped into [-pi, pi)
  function automatic longint heading_angle(longint x, longint y);
    longint acc, xs, ys, a;
    int i;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (y == 0) return (x > 0) ? 0 : -HALF_TURN;
    if (x == 0) return (y > 0) ? HALF_TURN / 2 : -(HALF_TURN / 2);
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 64'sd1 <<< (ACC_W - 1);
    end
    x = x * 65536;
    y = y * 65536;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        acc += longint'(ATAN_TAB[i]);
      end else begin
        x -= ys;
        y += xs;
        acc -= longint'(ATAN_TAB[i]);
      end
    end
    a = (acc + (64'sd1 <<< (ACC_SHIFT - 1))) >>> ACC_SHIFT;
    while (a >= HALF_TURN) a -= 2 * HALF_TURN;
    while (a < -HALF_TURN) a += 2 * HALF_TURN;
    return a;
  endfunction

  function automatic wheel_cmd_t predict_wheel_speeds(logic signed [CW-1:0] hx,
                                                      logic signed [CW-1:0] hy);
    wheel_cmd_t cmd;
    longint x, y, ang, absang, len, base, t, slow, fast, lft, rgt;
    x = hx;
    y = hy;
    ang = heading_angle(x, y);
    absang = (ang < 0) ? -ang : ang;
    len = longint'(floor_sqrt(x * x + y * y));
    base = (len < cfg_max_speed) ? len : cfg_max_speed;
    if (absang <= cfg_no_turn) begin
      cmd.mode = MODE_STRAIGHT;
      slow = base;
      fast = base;
    end else if (absang <= cfg_soft_turn) begin
      t = (base * absang + cfg_soft_turn / 2) / cfg_soft_turn;
      cmd.mode = MODE_SOFT;
      slow = base - t;
      fast = base + t;
      if (slow > cfg_max_speed) slow = cfg_max_speed;
      if (fast > cfg_max_speed) fast = cfg_max_speed;
      if (slow < -cfg_max_speed) slow = -cfg_max_speed;
      if (fast < -cfg_max_speed) fast = -cfg_max_speed;
    end else begin
      cmd.mode = MODE_HARD;
      slow = -cfg_max_speed;
      fast = cfg_max_speed;
    end
    // positive angle: slow wheel on the left
    lft = (ang > 0) ? slow : fast;
    rgt = (ang > 0) ? fast : slow;
    cmd.left_speed  = lft[SPEED_W-1:0];
    cmd.right_speed = rgt[SPEED_W-1:0];
    return cmd;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    wheel_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_speeds.size() == 0) begin
        report_mismatch("result transaction with no expectation waiting");
      end else begin
        want = pending_speeds.pop_front();
        if (left_speed !== want.left_speed)
          report_mismatch($sformatf("left_speed %0d, expected %0d", left_speed,
                                    want.left_speed));
        if (right_speed !== want.right_speed)
          report_mismatch($sformatf("right_speed %0d, expected %0d", right_speed,
                                    want.right_speed));
        if (turn_mode !== want.mode)
          report_mismatch($sformatf("turn_mode %0d, expected %0d", turn_mode, want.mode));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  task automatic send_heading(input logic signed [CW-1:0] hx, input logic signed [CW-1:0] hy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    heading_x <= hx;
    heading_y <= hy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_speeds.push_back(predict_wheel_speeds(hx, hy));
  endtask

  // hold the input idle until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_SPEED: cfg_max_speed = data[MAX_SPEED_W-1:0];
      REG_NO_TURN:   cfg_no_turn   = data[THR_W-1:0];
      REG_SOFT_TURN: cfg_soft_turn = data[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic randomize_settings();
    logic [CFG_DATA_W-1:0] spd, lo, hi;
    case ($urandom_range(4))
      0: begin
        spd = MAX_SPEED_RST;
        lo  = NO_TURN_RST;
        hi  = SOFT_TURN_RST;
      end
      1: begin
        spd = CFG_DATA_W'($urandom);
        lo  = CFG_DATA_W'($urandom);
        hi  = CFG_DATA_W'($urandom);
      end
      default: begin
        spd = CFG_DATA_W'($urandom_range(8000));
        lo  = CFG_DATA_W'($urandom_range(6000));
        hi  = lo + CFG_DATA_W'($urandom_range(20000));
      end
    endcase
    write_setting(REG_MAX_SPEED, spd);
    write_setting(REG_NO_TURN, lo);
    write_setting(REG_SOFT_TURN, hi);
  endtask

  function automatic logic signed [CW-1:0] random_component();
    logic signed [CW-1:0] pick;
    case ($urandom_range(9))
      0, 1, 2, 3: pick = CW'($urandom);
      4, 5, 6:    pick = CW'(int'($urandom_range(6000)) - 3000);
      7: begin
        case ($urandom_range(4))
          0:       pick = {1'b1, {(CW-1){1'b0}}};
          1:       pick = {1'b0, {(CW-1){1'b1}}};
          2:       pick = -1;
          3:       pick = 1;
          default: pick = 0;
        endcase
      end
      default: pick = 0;
    endcase
    return pick;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_headings();
    send_heading(0, 0);
    send_heading(32767, 0);
    send_heading(-32768, 0);
    send_heading(0, 32767);
    send_heading(0, -32768);
    send_heading(32767, 32767);
    send_heading(-32768, -32768);
    send_heading(32767, -32768);
    send_heading(-32768, 32767);
    send_heading(1000, 200);
    send_heading(1000, -200);
    send_heading(1000, 1000);
    send_heading(100, 1000);
    send_heading(-1000, 10);
    send_heading(-1, -1);
    drain_results();
  endtask

  task automatic test_setting_extremes();
    write_setting(REG_MAX_SPEED, '0);
    send_heading(500, 300);
    send_heading(-32768, 5);
    drain_results();
    write_setting(REG_MAX_SPEED, '1);
    write_setting(REG_NO_TURN, '0);
    write_setting(REG_SOFT_TURN, 16'h7FFF);
    send_heading(32767, 32767);
    send_heading(-32768, 1);
    send_heading(20000, -3);
    drain_results();
    // thresholds reversed; the top data bit must be dropped
    write_setting(REG_NO_TURN, '1);
    write_setting(REG_SOFT_TURN, '0);
    send_heading(0, -5);
    send_heading(-7, 0);
    drain_results();
    write_setting(REG_UNUSED, 16'h1234);
    write_setting(REG_NO_TURN, 16'd5000);
    write_setting(REG_SOFT_TURN, 16'd5000);
    send_heading(30000, 100);
    send_heading(3000, 2000);
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    drain_results();
    randomize_settings();
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) send_heading(random_component(), random_component());
    drain_results();
  endtask

  task automatic test_output_backpressure();
    drain_results();
    randomize_settings();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    // hold the output long enough for the pipeline to fill and stall the input
    fork
      begin
        stall_hold <= 1'b1;
        repeat (4 * DUT_LATENCY) @(posedge clk);
        stall_hold <= 1'b0;
      end
    join_none
    repeat (150) send_heading(random_component(), random_component());
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_headings();
    test_setting_extremes();
    test_random_traffic(260, 0, 0);
    test_random_traffic(260, 79, 0);
    test_random_traffic(260, 0, 79);
    test_output_backpressure();
    test_random_traffic(260, 32, 32);
    drain_results();
    repeat (DUT_LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
